/* design/page_residency_manager_defines.svh */
// Assertion macros shared by the page residency manager RTL.
`ifndef PAGE_RESIDENCY_MANAGER_DEFINES_SVH
`define PAGE_RESIDENCY_MANAGER_DEFINES_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define PRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define PRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PRM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* design/prm_pkg.sv */
// Types and constants of the page residency manager.
`default_nettype none
package prm_pkg;
    localparam int PAGES      = 1024;
    localparam int SLOTS      = 256;
    localparam int USAGE_BITS = 16;
    localparam int PAGE_W     = 10;
    localparam int SLOT_W     = 8;
    localparam int SLOTF_W    = 9;
    localparam int FLAG_W     = 3;
    localparam int TRY_W      = 11;
    localparam int LIM_W      = 9;
    localparam int SCAN_W     = 5;
    localparam int LFSR_W     = 16;

    localparam logic [SLOTF_W-1:0] NO_SLOT   = SLOTF_W'(SLOTS);
    localparam logic [TRY_W-1:0]   TRIES_MAX = TRY_W'(4 * SLOTS);
    localparam logic [LFSR_W-1:0]  LFSR_TAPS = 16'hB400;

    localparam int FLAG_ZERO  = 0;
    localparam int FLAG_LOCK  = 1;
    localparam int FLAG_WRITE = 2;

    localparam logic [2:0] CMD_ACCESS = 3'd0;
    localparam logic [2:0] CMD_LOCK   = 3'd1;
    localparam logic [2:0] CMD_UNLOCK = 3'd2;
    localparam logic [2:0] CMD_SWAP   = 3'd3;
    localparam logic [2:0] CMD_WR_ON  = 3'd4;
    localparam logic [2:0] CMD_WR_OFF = 3'd5;
    localparam logic [2:0] CMD_CLEAR  = 3'd6;
    localparam logic [2:0] CMD_USAGE  = 3'd7;

    localparam logic [2:0] ACT_DONE  = 3'd0;
    localparam logic [2:0] ACT_EVC   = 3'd1;
    localparam logic [2:0] ACT_EVW   = 3'd2;
    localparam logic [2:0] ACT_ZFILL = 3'd3;
    localparam logic [2:0] ACT_RFILL = 3'd4;
    localparam logic [2:0] ACT_BAD   = 3'd5;
    localparam logic [2:0] ACT_LOCKV = 3'd6;
    localparam logic [2:0] ACT_NOVIC = 3'd7;

    localparam logic [1:0] REG_LIMIT = 2'd0;
    localparam logic [1:0] REG_SCAN  = 2'd1;
    localparam logic [1:0] REG_SEED  = 2'd2;

    localparam logic [LIM_W-1:0]  LIMIT_RST = 9'd256;
    localparam logic [SCAN_W-1:0] SCAN_RST  = 5'd10;
    localparam logic [LFSR_W-1:0] SEED_RST  = 16'd44257;

    typedef struct packed {
        logic [FLAG_W-1:0]     flags;
        logic [SLOTF_W-1:0]    slot;
        logic [USAGE_BITS-1:0] usage;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [LIM_W-1:0]  lim;
        logic [SCAN_W-1:0] want;
        logic              seed_ld;
        logic [LFSR_W-1:0] seed;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [2:0]        action;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_result;
endpackage
`default_nettype wire

/* design/prm_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module prm_ram #(
    parameter int W  = 8,
    parameter int AW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [(1 << AW)];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* design/prm_mod.sv */
// Bit-serial remainder unit: sample value modulo the effective resident limit.
`default_nettype none
module prm_mod import prm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [LFSR_W-1:0] i_dividend,
    input  wire logic [LIM_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [SLOT_W-1:0]      o_rem
);
    logic [LFSR_W-1:0] r_dvd;
    logic [LIM_W-1:0]  r_div;
    logic [LIM_W-1:0]  r_rem;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [LIM_W:0]    trial;
    logic [LIM_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[LFSR_W-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = LIM_W'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[LIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(LFSR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[LFSR_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[SLOT_W-1:0];
endmodule
`default_nettype wire

/* design/prm_seq.sv */
// Command sequencer: read-modify-write of the page, slot and free-stack memories.
`default_nettype none
`include "page_residency_manager_defines.svh"
module prm_seq import prm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [2:0]            i_cmd,
    input  wire logic [PAGE_W-1:0]     i_page,
    input  wire logic [USAGE_BITS-1:0] i_usage_value,
    input  wire logic                  i_out_rdy,
    output t_result                    o_res
);
    typedef enum logic [10:0] {
        S_CLR    = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_DEC    = 11'b00000000100,
        S_SAMP   = 11'b00000001000,
        S_MOD    = 11'b00000010000,
        S_OWN    = 11'b00000100000,
        S_CAND   = 11'b00001000000,
        S_EVICT  = 11'b00010000000,
        S_FILL   = 11'b00100000000,
        S_FILLRD = 11'b01000000000,
        S_FILLW  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [PAGE_W-1:0]     r_clr;
    logic [2:0]            r_cmd;
    logic [PAGE_W-1:0]     r_page;
    logic [USAGE_BITS-1:0] r_uv;
    t_entry                r_ent;
    logic [SLOTF_W-1:0]    r_free_depth, n_free_depth;
    logic [SLOTF_W-1:0]    r_fresh_next, n_fresh_next;
    logic [SLOTF_W-1:0]    r_res_cnt, n_res_cnt;
    logic [LFSR_W-1:0]     r_lfsr, n_lfsr;
    logic [TRY_W-1:0]      r_tries;
    logic [SCAN_W-1:0]     r_scanned;
    logic                  r_have;
    logic [PAGE_W-1:0]     r_cand;
    logic [PAGE_W-1:0]     r_best_page;
    t_entry                r_best_ent;
    logic [SLOT_W-1:0]     r_sl;

    // Memory ports.
    logic                  pm_we;
    logic [PAGE_W-1:0]     pm_waddr, pm_raddr;
    t_entry                pm_wdata, pm_rdata;
    logic                  so_we;
    logic [SLOT_W-1:0]     so_waddr, so_raddr;
    logic [PAGE_W-1:0]     so_wdata, so_rdata;
    logic                  fs_we;
    logic [SLOT_W-1:0]     fs_waddr, fs_raddr;
    logic [SLOT_W-1:0]     fs_rdata;

    logic                  mod_start, mod_done;
    logic [SLOT_W-1:0]     mod_rem;
    logic [LFSR_W-1:0]     lfsr_step;

    // Shared eviction bookkeeping.
    logic                  ev_do;
    logic [SLOT_W-1:0]     ev_slot;

    logic                  fire;
    t_result               res;
    logic                  locked, resident, cand;
    t_entry                ent_new;

    prm_ram #(.W(ENTRY_W), .AW(PAGE_W)) u_page_mem (
        .i_clk(i_clk), .i_we(pm_we), .i_waddr(pm_waddr), .i_wdata(pm_wdata),
        .i_raddr(pm_raddr), .o_rdata(pm_rdata)
    );
    prm_ram #(.W(PAGE_W), .AW(SLOT_W)) u_owner_mem (
        .i_clk(i_clk), .i_we(so_we), .i_waddr(so_waddr), .i_wdata(so_wdata),
        .i_raddr(so_raddr), .o_rdata(so_rdata)
    );
    prm_ram #(.W(SLOT_W), .AW(SLOT_W)) u_free_mem (
        .i_clk(i_clk), .i_we(fs_we), .i_waddr(fs_waddr), .i_wdata(ev_slot),
        .i_raddr(fs_raddr), .o_rdata(fs_rdata)
    );
    prm_mod u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mod_start),
        .i_dividend(lfsr_step), .i_divisor(i_cfg.lim),
        .o_done(mod_done), .o_rem(mod_rem)
    );

    assign lfsr_step = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : '0);
    assign locked    = pm_rdata.flags[FLAG_LOCK];
    assign resident  = (pm_rdata.slot == NO_SLOT) ? 1'b0 : 1'b1;
    assign cand      = !pm_rdata.slot[SLOTF_W-1] && !pm_rdata.flags[FLAG_LOCK];
    assign fire      = res.valid && i_out_rdy;
    assign o_ready   = (r_state == S_IDLE);
    assign o_res     = res;

    always_comb begin
        n_state      = r_state;
        res          = '0;
        res.page     = r_page;
        res.last     = 1'b1;
        pm_we        = 1'b0;
        pm_waddr     = r_page;
        pm_wdata     = pm_rdata;
        pm_raddr     = r_page;
        so_we        = 1'b0;
        so_waddr     = ev_slot;
        so_wdata     = '0;
        so_raddr     = mod_rem;
        fs_raddr     = SLOT_W'(r_free_depth - SLOTF_W'(1));
        mod_start    = 1'b0;
        ev_do        = 1'b0;
        ev_slot      = pm_rdata.slot[SLOT_W-1:0];
        n_lfsr       = r_lfsr;
        ent_new      = pm_rdata;
        case (r_state)
            S_CLR: begin
                pm_we          = 1'b1;
                pm_waddr       = r_clr;
                pm_wdata.flags = FLAG_W'(1) << FLAG_ZERO;
                pm_wdata.slot  = NO_SLOT;
                pm_wdata.usage = '0;
                so_we          = ({1'b0, r_clr} < (PAGE_W + 1)'(SLOTS));
                so_waddr       = r_clr[SLOT_W-1:0];
                if (r_clr == PAGE_W'(PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                pm_raddr = i_page;
                if (i_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                res.valid = 1'b1;
                res.action = ACT_DONE;
                case (r_cmd)
                    CMD_ACCESS, CMD_LOCK: begin
                        if (r_cmd == CMD_LOCK && locked) begin
                            res.action = ACT_LOCKV;
                        end else if (resident) begin
                            ent_new.flags[FLAG_LOCK] = (r_cmd == CMD_LOCK) ? 1'b1 : locked;
                            pm_we = fire;
                        end else begin
                            res.valid = 1'b0;
                            if (r_res_cnt >= i_cfg.lim) begin
                                n_state = S_SAMP;
                            end else begin
                                n_state = S_FILL;
                            end
                        end
                    end
                    CMD_UNLOCK: begin
                        if (!locked) begin
                            res.action = ACT_LOCKV;
                        end else begin
                            ent_new.flags[FLAG_LOCK] = 1'b0;
                            pm_we = fire;
                        end
                    end
                    CMD_SWAP, CMD_CLEAR: begin
                        if (locked) begin
                            res.action = ACT_LOCKV;
                        end else begin
                            if (r_cmd == CMD_CLEAR) begin
                                ent_new.flags[FLAG_WRITE] = 1'b0;
                                ent_new.flags[FLAG_ZERO]  = 1'b1;
                                ent_new.usage             = '0;
                            end
                            if (resident) begin
                                ent_new.slot = NO_SLOT;
                                ev_do        = fire;
                                res.slot     = pm_rdata.slot[SLOT_W-1:0];
                                res.action   = (pm_rdata.flags[FLAG_WRITE] &&
                                                r_cmd == CMD_SWAP) ? ACT_EVW : ACT_EVC;
                            end
                            pm_we = fire;
                        end
                    end
                    CMD_WR_ON: begin
                        ent_new.flags[FLAG_WRITE] = 1'b1;
                        pm_we = fire;
                    end
                    CMD_WR_OFF: begin
                        ent_new.flags[FLAG_WRITE] = 1'b0;
                        pm_we = fire;
                    end
                    default: begin
                        ent_new.usage = r_uv[USAGE_BITS-1:0];
                        pm_we = fire;
                    end
                endcase
                pm_wdata = ent_new;
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            S_SAMP: begin
                if (r_scanned >= i_cfg.want) begin
                    n_state = S_EVICT;
                end else if (r_tries == TRIES_MAX) begin
                    res.valid  = 1'b1;
                    res.action = ACT_NOVIC;
                    if (fire) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_lfsr    = lfsr_step;
                    mod_start = 1'b1;
                    n_state   = S_MOD;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_state = S_OWN;
                end
            end
            S_OWN: begin
                pm_raddr = so_rdata;
                n_state  = S_CAND;
            end
            S_CAND: begin
                n_state = S_SAMP;
            end
            S_EVICT: begin
                res.valid      = 1'b1;
                res.last       = 1'b0;
                res.page       = r_best_page;
                res.slot       = r_best_ent.slot[SLOT_W-1:0];
                res.action     = r_best_ent.flags[FLAG_WRITE] ? ACT_EVW : ACT_EVC;
                ev_slot        = r_best_ent.slot[SLOT_W-1:0];
                ev_do          = fire;
                pm_we          = fire;
                pm_waddr       = r_best_page;
                pm_wdata       = r_best_ent;
                pm_wdata.slot  = NO_SLOT;
                if (fire) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (r_free_depth != '0) begin
                    n_state = S_FILLRD;
                end else if (r_fresh_next < NO_SLOT) begin
                    n_state = S_FILLW;
                end else begin
                    res.valid  = 1'b1;
                    res.action = ACT_NOVIC;
                    if (fire) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FILLRD: begin
                n_state = S_FILLW;
            end
            S_FILLW: begin
                res.valid      = 1'b1;
                res.slot       = r_sl;
                res.action     = r_ent.flags[FLAG_ZERO] ? ACT_ZFILL : ACT_RFILL;
                so_we          = fire;
                so_waddr       = r_sl;
                so_wdata       = r_page;
                pm_we          = fire;
                pm_wdata       = r_ent;
                pm_wdata.slot  = {1'b0, r_sl};
                pm_wdata.flags[FLAG_ZERO] = 1'b0;
                if (r_cmd == CMD_LOCK) begin
                    pm_wdata.flags[FLAG_LOCK] = 1'b1;
                end
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (ev_do) begin
            so_we    = 1'b1;
            so_waddr = ev_slot;
            so_wdata = '0;
        end
    end

    // Free stack push on eviction, pop in the fill path; resident count follows.
    assign fs_we    = ev_do && (r_free_depth < NO_SLOT);
    assign fs_waddr = r_free_depth[SLOT_W-1:0];

    always_comb begin
        n_free_depth = r_free_depth;
        n_fresh_next = r_fresh_next;
        n_res_cnt    = r_res_cnt;
        if (ev_do) begin
            if (r_free_depth < NO_SLOT) begin
                n_free_depth = r_free_depth + SLOTF_W'(1);
            end
            if (r_res_cnt != '0) begin
                n_res_cnt = r_res_cnt - SLOTF_W'(1);
            end
        end
        if (r_state == S_FILLRD) begin
            n_free_depth = r_free_depth - SLOTF_W'(1);
        end
        if (r_state == S_FILL && r_free_depth == '0 && r_fresh_next < NO_SLOT) begin
            n_fresh_next = r_fresh_next + SLOTF_W'(1);
        end
        if (r_state == S_FILLW && fire) begin
            n_res_cnt = r_res_cnt + SLOTF_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_free_depth <= '0;
            r_fresh_next <= '0;
            r_res_cnt    <= '0;
            r_lfsr       <= SEED_RST;
        end else begin
            r_state      <= n_state;
            r_clr        <= r_clr + PAGE_W'(1);
            r_free_depth <= n_free_depth;
            r_fresh_next <= n_fresh_next;
            r_res_cnt    <= n_res_cnt;
            if (i_cfg.seed_ld) begin
                r_lfsr <= (i_cfg.seed == '0) ? LFSR_W'(1) : i_cfg.seed;
            end else begin
                r_lfsr <= n_lfsr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cmd  <= i_cmd;
            r_page <= i_page;
            r_uv   <= i_usage_value;
        end
        if (r_state == S_DEC) begin
            r_ent     <= pm_rdata;
            r_scanned <= '0;
            r_tries   <= '0;
            r_have    <= 1'b0;
        end
        if (r_state == S_SAMP && n_state == S_MOD) begin
            r_tries <= r_tries + TRY_W'(1);
        end
        if (r_state == S_OWN) begin
            r_cand <= so_rdata;
        end
        if (r_state == S_CAND && cand) begin
            r_scanned <= r_scanned + SCAN_W'(1);
            if (!r_have || pm_rdata.usage < r_best_ent.usage) begin
                r_have      <= 1'b1;
                r_best_page <= r_cand;
                r_best_ent  <= pm_rdata;
            end
        end
        if (r_state == S_FILLRD) begin
            r_sl <= fs_rdata;
        end else if (r_state == S_FILL) begin
            r_sl <= r_fresh_next[SLOT_W-1:0];
        end
    end

    // Every allocated slot is either held by a resident page or on the free stack,
    // except while a fill holds its taken slot before the resident count follows.
    `PRM_ASSERT_IMP(a_slot_balance, i_clk, i_rst_n, r_state != S_CLR && r_state != S_FILLW,
        ({1'b0, r_res_cnt} + {1'b0, r_free_depth}) == {1'b0, r_fresh_next},
        "slot accounting out of balance")
    `PRM_ASSERT_IMP(a_res_bound, i_clk, i_rst_n, 1'b1, r_res_cnt <= NO_SLOT,
        "resident count above slot count")
    `PRM_ASSERT_IMP(a_first_is_evict, i_clk, i_rst_n, fire && !res.last,
        res.action == ACT_EVC || res.action == ACT_EVW,
        "non-final word is not an eviction")
    `PRM_ASSERT_NEXT(a_fill_done, i_clk, i_rst_n, r_state == S_FILLW && fire,
        r_state == S_IDLE, "fill did not end the command")
endmodule
`default_nettype wire

/* design/page_residency_manager.sv */
// Top level of the page residency manager: register port, sequencer and output register.
`default_nettype none
// The page residency manager tracks 1024 pages, of which up to resident_limit live in
// 256 memory slots. Each input word carries one command on one page (access, lock,
// unlock, swap out, write on, write off, clear, set usage) and yields one or two
// result words; when there are two, the first is an eviction and only the second
// has last set. A miss at the resident limit samples slots with a 16-bit LFSR and
// evicts the least-used unlocked page among scan_count candidates. The block works
// on one word at a time and takes no new input word until the last one is through.
// A hit or a simple flag update puts its result word out from the decode state
// through the output register; a miss with a free slot puts out its fill word
// from a fresh slot, or from one that comes off the free stack after a stack read;
// a miss that must evict runs one sampling try after another, each made of the
// 16-step bit-serial remainder unit followed by the slot-owner and page-table
// memory reads, and gives up with no victim after 1024 tries. After reset the
// page table is cleared in a pass over all 1024 pages, during which input words are
// stalled; register writes are taken at any time but must only be issued while the
// block is idle.
module page_residency_manager import prm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [2:0]            i_cmd,
    input  wire logic [PAGE_W-1:0]     i_page,
    input  wire logic [USAGE_BITS-1:0] i_usage_value,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [2:0]            o_action,
    output logic      [PAGE_W-1:0]     o_page_out,
    output logic      [SLOT_W-1:0]     o_slot,
    output logic                       o_last
);
    logic [LIM_W-1:0]  r_limit;
    logic [SCAN_W-1:0] r_scan;
    logic [LFSR_W-1:0] r_seed;
    logic              r_seed_ld;
    logic              wr;
    t_cfg              cfg;
    logic              seq_ready;
    logic              out_rdy;
    t_result           res;
    t_result           r_out;

    // Register writes complete on the access phase; pready is tied high.
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RST;
            r_scan    <= SCAN_RST;
            r_seed    <= SEED_RST;
            r_seed_ld <= 1'b0;
        end else begin
            r_seed_ld <= 1'b0;
            if (wr) begin
                case (paddr[3:2])
                    REG_LIMIT: r_limit <= pwdata[LIM_W-1:0];
                    REG_SCAN:  r_scan  <= pwdata[SCAN_W-1:0];
                    REG_SEED: begin
                        r_seed    <= pwdata[LFSR_W-1:0];
                        r_seed_ld <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LIMIT: prdata = {{(32 - LIM_W){1'b0}}, r_limit};
            REG_SCAN:  prdata = {{(32 - SCAN_W){1'b0}}, r_scan};
            REG_SEED:  prdata = {{(32 - LFSR_W){1'b0}}, r_seed};
            default:   prdata = '0;
        endcase
    end

    // A limit of zero acts as one and one above the slot count as the slot count;
    // a scan count of zero acts as one. The LFSR is reloaded through a registered load
    // strobe after a seed write, and on reset it starts from the reset seed.
    always_comb begin
        cfg.lim = r_limit;
        if (r_limit == '0) begin
            cfg.lim = LIM_W'(1);
        end else if (r_limit > LIM_W'(SLOTS)) begin
            cfg.lim = LIM_W'(SLOTS);
        end
        cfg.want    = (r_scan == '0) ? SCAN_W'(1) : r_scan;
        cfg.seed_ld = r_seed_ld;
        cfg.seed    = r_seed;
    end

    prm_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg),
        .i_valid(i_valid), .o_ready(seq_ready),
        .i_cmd(i_cmd), .i_page(i_page), .i_usage_value(i_usage_value),
        .i_out_rdy(out_rdy), .o_res(res)
    );

    assign o_stall = !seq_ready;

    // Output register: the sequencer hands over a word whenever the register is
    // empty or its word is being taken in the same cycle.
    assign out_rdy = !r_out.valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (out_rdy) begin
            r_out.valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && res.valid) begin
            r_out.action <= res.action;
            r_out.page   <= res.page;
            r_out.slot   <= res.slot;
            r_out.last   <= res.last;
        end
    end

    assign o_valid    = r_out.valid;
    assign o_action   = r_out.action;
    assign o_page_out = r_out.page;
    assign o_slot     = r_out.slot;
    assign o_last     = r_out.last;
endmodule
`default_nettype wire
